/* rtl/core/jts_pkg.sv */
package jts_pkg;

	// Width of the running byte offset and of the saved lexeme start.
	localparam int OFFSET_BITS = 32;

	localparam int KIND_BITS  = 4;
	localparam int FIELD_BITS = 32;

	// Token kinds as they appear on the result channel.
	localparam logic [KIND_BITS-1:0] KIND_LBRACE   = 4'd0;
	localparam logic [KIND_BITS-1:0] KIND_RBRACE   = 4'd1;
	localparam logic [KIND_BITS-1:0] KIND_COLON    = 4'd2;
	localparam logic [KIND_BITS-1:0] KIND_COMMA    = 4'd3;
	localparam logic [KIND_BITS-1:0] KIND_LBRACKET = 4'd4;
	localparam logic [KIND_BITS-1:0] KIND_RBRACKET = 4'd5;
	localparam logic [KIND_BITS-1:0] KIND_STRING   = 4'd6;
	localparam logic [KIND_BITS-1:0] KIND_INTEGER  = 4'd7;
	localparam logic [KIND_BITS-1:0] KIND_REAL     = 4'd8;
	localparam logic [KIND_BITS-1:0] KIND_TRUE     = 4'd9;
	localparam logic [KIND_BITS-1:0] KIND_FALSE    = 4'd10;
	localparam logic [KIND_BITS-1:0] KIND_NULL     = 4'd11;
	localparam logic [KIND_BITS-1:0] KIND_INVALID  = 4'd12;
	localparam logic [KIND_BITS-1:0] KIND_END      = 4'd13;

	// One byte can produce a closing token, a one-byte token, a flushed token
	// and the end token; at most three of these occur together.
	localparam int SLOTS = 4;

	typedef struct packed {
		logic [KIND_BITS-1:0]  kind;
		logic [FIELD_BITS-1:0] start;
		logic [FIELD_BITS-1:0] length;
	} jts_token_t;

	typedef struct packed {
		logic [SLOTS-1:0]             vld;
		jts_token_t [SLOTS-1:0]       tok;
	} jts_batch_t;

endpackage

/* rtl/core/jts_in_if.sv */
interface jts_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_in;
	logic       doc_last;

	modport source (output valid, output byte_in, output doc_last, input ready);
	modport sink (input valid, input byte_in, input doc_last, output ready);
endinterface

/* rtl/core/jts_out_if.sv */
interface jts_out_if;
	logic        valid;
	logic        ready;
	logic [3:0]  token_kind;
	logic [31:0] token_start;
	logic [31:0] token_length;
	logic        run_last;

	modport source (output valid, output token_kind, output token_start,
		output token_length, output run_last, input ready);
	modport sink (input valid, input token_kind, input token_start,
		input token_length, input run_last, output ready);
endinterface

/* rtl/core/jts_lexer.sv */
module jts_lexer (
	input  logic               clk,
	input  logic               arst_n,
	jts_in_if.sink             bytes,
	output jts_pkg::jts_batch_t batch,
	output logic               batch_valid,
	input  logic               batch_ready
);

	localparam int OB = jts_pkg::OFFSET_BITS;

	localparam logic [3:0] MODE_IDLE    = 4'd0;
	localparam logic [3:0] MODE_STRING  = 4'd1;
	localparam logic [3:0] MODE_WORD    = 4'd2;
	localparam logic [3:0] MODE_SIGN    = 4'd3;
	localparam logic [3:0] MODE_INT     = 4'd4;
	localparam logic [3:0] MODE_DOT     = 4'd5;
	localparam logic [3:0] MODE_FRAC    = 4'd6;
	localparam logic [3:0] MODE_EXP     = 4'd7;
	localparam logic [3:0] MODE_EXPSIGN = 4'd8;
	localparam logic [3:0] MODE_EXPDIG  = 4'd9;

	localparam logic [7:0] CH_QUOTE    = 8'h22;
	localparam logic [7:0] CH_DOT      = 8'h2E;
	localparam logic [7:0] CH_PLUS     = 8'h2B;
	localparam logic [7:0] CH_MINUS    = 8'h2D;
	localparam logic [7:0] CH_LOW_E    = 8'h65;
	localparam logic [7:0] CH_UP_E     = 8'h45;
	localparam logic [7:0] CH_LBRACE   = 8'h7B;
	localparam logic [7:0] CH_RBRACE   = 8'h7D;
	localparam logic [7:0] CH_COLON    = 8'h3A;
	localparam logic [7:0] CH_COMMA    = 8'h2C;
	localparam logic [7:0] CH_LBRACKET = 8'h5B;
	localparam logic [7:0] CH_RBRACKET = 8'h5D;

	localparam logic [5:0] KW_ALL = 6'h3F;
	localparam logic [7:0] KW_TEXT [6][5] = '{
		'{"t", "r", "u", "e", 8'h00},
		'{"T", "R", "U", "E", 8'h00},
		'{"f", "a", "l", "s", "e"},
		'{"F", "A", "L", "S", "E"},
		'{"n", "u", "l", "l", 8'h00},
		'{"N", "U", "L", "L", 8'h00}
	};
	localparam logic [2:0] KW_LEN [6] = '{3'd4, 3'd4, 3'd5, 3'd5, 3'd4, 3'd4};
	localparam logic [3:0] KW_KIND [6] = '{
		jts_pkg::KIND_TRUE, jts_pkg::KIND_TRUE, jts_pkg::KIND_FALSE,
		jts_pkg::KIND_FALSE, jts_pkg::KIND_NULL, jts_pkg::KIND_NULL
	};

	typedef struct packed {
		logic [2:0] idx;
		logic [5:0] cand;
	} word_t;

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return c == " " || (c >= 8'd9 && c <= 8'd13);
	endfunction

	// Advance the keyword matcher by one letter.
	function automatic word_t word_feed(input word_t w, input logic [7:0] c);
		word_t r;
		r = w;
		for (int k = 0; k < 6; k++) begin
			if (w.idx >= KW_LEN[k] || KW_TEXT[k][w.idx] != c) begin
				r.cand[k] = 1'b0;
			end
		end
		if (w.idx != 3'd7) begin
			r.idx = w.idx + 3'd1;
		end
		return r;
	endfunction

	// The first spelling still possible whose length matches wins.
	function automatic logic [3:0] word_kind(input word_t w);
		logic [3:0] kind;
		kind = jts_pkg::KIND_INVALID;
		for (int k = 5; k >= 0; k--) begin
			if (w.cand[k] && w.idx == KW_LEN[k]) begin
				kind = KW_KIND[k];
			end
		end
		return kind;
	endfunction

	// Clamp a length to the 32-bit result field.
	function automatic logic [31:0] len_sat(input logic [OB:0] v);
		logic [64:0] w;
		w = 65'(v);
		if (w > 65'(32'hFFFF_FFFF)) begin
			return 32'hFFFF_FFFF;
		end
		return w[31:0];
	endfunction

	logic          valid_s1;
	logic [7:0]    byte_s1;
	logic          last_s1;

	logic [3:0]    mode_q;
	logic [OB-1:0] off_q;
	logic [OB-1:0] start_q;
	word_t         word_q;

	logic [3:0]    mode_n;
	logic [OB-1:0] off_n;
	logic [OB-1:0] start_n;
	word_t         word_n;

	logic [3:0]    cur_mode;
	logic          consumed;
	logic          ends;
	logic [3:0]    end_kind;
	logic [3:0]    flush_kind;
	logic [OB-1:0] d_cur;
	logic [OB-1:0] d_new;
	logic [OB-1:0] end_off;
	logic          advance;

	assign advance     = valid_s1 && batch_ready;
	assign batch_valid = valid_s1;
	assign bytes.ready = !valid_s1 || batch_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bytes.valid && bytes.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.valid && bytes.ready) begin
			byte_s1 <= bytes.byte_in;
			last_s1 <= bytes.doc_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			off_q   <= '0;
			start_q <= '0;
			word_q  <= '{idx: 3'd0, cand: KW_ALL};
		end else if (advance) begin
			mode_q  <= mode_n;
			off_q   <= off_n;
			start_q <= start_n;
			word_q  <= word_n;
		end
	end

	assign d_cur   = off_q - start_q;
	assign d_new   = off_q - start_n;
	assign end_off = (&off_q) ? off_q : off_q + OB'(1);

	always_comb begin
		cur_mode = (mode_q > MODE_EXPDIG) ? MODE_IDLE : mode_q;
		mode_n   = cur_mode;
		off_n    = off_q;
		start_n  = start_q;
		word_n   = word_q;
		consumed = 1'b1;
		ends     = 1'b0;
		end_kind = jts_pkg::KIND_INVALID;
		flush_kind = jts_pkg::KIND_INVALID;
		batch    = '0;

		// Continue, close or end the token in progress.
		case (cur_mode)
			MODE_STRING: begin
				if (byte_s1 == CH_QUOTE) begin
					batch.vld[0] = 1'b1;
					batch.tok[0] = '{last_s1 ? jts_pkg::KIND_INVALID : jts_pkg::KIND_STRING,
						32'(start_q), len_sat({1'b0, d_cur} + (OB+1)'(1))};
					mode_n = MODE_IDLE;
				end
			end
			MODE_WORD: begin
				if (is_alpha(byte_s1)) begin
					word_n = word_feed(word_q, byte_s1);
				end else begin
					ends     = 1'b1;
					end_kind = word_kind(word_q);
				end
			end
			MODE_SIGN: begin
				if (is_digit(byte_s1)) mode_n = MODE_INT;
				else ends = 1'b1;
			end
			MODE_INT: begin
				if (byte_s1 == CH_DOT) begin
					mode_n = MODE_DOT;
				end else if (!is_digit(byte_s1)) begin
					ends     = 1'b1;
					end_kind = jts_pkg::KIND_INTEGER;
				end
			end
			MODE_DOT: begin
				if (is_digit(byte_s1)) mode_n = MODE_FRAC;
				else ends = 1'b1;
			end
			MODE_FRAC: begin
				if (byte_s1 == CH_LOW_E || byte_s1 == CH_UP_E) begin
					mode_n = MODE_EXP;
				end else if (!is_digit(byte_s1)) begin
					ends     = 1'b1;
					end_kind = jts_pkg::KIND_REAL;
				end
			end
			MODE_EXP: begin
				if (byte_s1 == CH_PLUS || byte_s1 == CH_MINUS) mode_n = MODE_EXPSIGN;
				else if (is_digit(byte_s1)) mode_n = MODE_EXPDIG;
				else ends = 1'b1;
			end
			MODE_EXPSIGN: begin
				if (is_digit(byte_s1)) mode_n = MODE_EXPDIG;
				else ends = 1'b1;
			end
			MODE_EXPDIG: begin
				if (!is_digit(byte_s1)) begin
					ends     = 1'b1;
					end_kind = jts_pkg::KIND_REAL;
				end
			end
			default: begin
				consumed = 1'b0;
			end
		endcase

		// The ending byte is not part of the finished token.
		if (ends) begin
			batch.vld[0] = 1'b1;
			batch.tok[0] = '{end_kind, 32'(start_q), len_sat({1'b0, d_cur})};
			mode_n   = MODE_IDLE;
			consumed = 1'b0;
		end

		// A byte that belongs to no pending token starts a new one.
		if (!consumed) begin
			case (byte_s1)
				CH_LBRACE: begin
					batch.vld[1] = 1'b1;
					batch.tok[1] = '{jts_pkg::KIND_LBRACE, 32'(off_q), 32'd1};
				end
				CH_RBRACE: begin
					batch.vld[1] = 1'b1;
					batch.tok[1] = '{jts_pkg::KIND_RBRACE, 32'(off_q), 32'd1};
				end
				CH_COLON: begin
					batch.vld[1] = 1'b1;
					batch.tok[1] = '{jts_pkg::KIND_COLON, 32'(off_q), 32'd1};
				end
				CH_COMMA: begin
					batch.vld[1] = 1'b1;
					batch.tok[1] = '{jts_pkg::KIND_COMMA, 32'(off_q), 32'd1};
				end
				CH_LBRACKET: begin
					batch.vld[1] = 1'b1;
					batch.tok[1] = '{jts_pkg::KIND_LBRACKET, 32'(off_q), 32'd1};
				end
				CH_RBRACKET: begin
					batch.vld[1] = 1'b1;
					batch.tok[1] = '{jts_pkg::KIND_RBRACKET, 32'(off_q), 32'd1};
				end
				CH_QUOTE: begin
					mode_n  = MODE_STRING;
					start_n = off_q;
				end
				CH_PLUS, CH_MINUS: begin
					mode_n  = MODE_SIGN;
					start_n = off_q;
				end
				default: begin
					if (is_space(byte_s1)) begin
						mode_n = MODE_IDLE;
					end else if (is_digit(byte_s1)) begin
						mode_n  = MODE_INT;
						start_n = off_q;
					end else if (is_alpha(byte_s1)) begin
						mode_n  = MODE_WORD;
						start_n = off_q;
						word_n  = word_feed('{idx: 3'd0, cand: KW_ALL}, byte_s1);
					end else begin
						batch.vld[1] = 1'b1;
						batch.tok[1] = '{jts_pkg::KIND_INVALID, 32'(off_q), 32'd1};
					end
				end
			endcase
		end

		case (mode_n)
			MODE_WORD:   flush_kind = word_kind(word_n);
			MODE_INT:    flush_kind = jts_pkg::KIND_INTEGER;
			MODE_FRAC:   flush_kind = jts_pkg::KIND_REAL;
			MODE_EXPDIG: flush_kind = jts_pkg::KIND_REAL;
			default:     flush_kind = jts_pkg::KIND_INVALID;
		endcase

		// Last byte: flush what is pending, add the end token, restart offsets.
		if (last_s1) begin
			if (mode_n != MODE_IDLE) begin
				batch.vld[2] = 1'b1;
				batch.tok[2] = '{flush_kind, 32'(start_n),
					len_sat({1'b0, d_new} + (OB+1)'(1))};
			end
			batch.vld[3] = 1'b1;
			batch.tok[3] = '{jts_pkg::KIND_END, 32'(end_off), 32'd0};
			mode_n  = MODE_IDLE;
			off_n   = '0;
			start_n = '0;
			word_n  = '{idx: 3'd0, cand: KW_ALL};
		end else if (!(&off_q)) begin
			off_n = off_q + OB'(1);
		end
	end

endmodule

/* rtl/core/jts_out.sv */
module jts_out (
	input  logic                clk,
	input  logic                arst_n,
	input  jts_pkg::jts_batch_t batch,
	input  logic                batch_valid,
	output logic                batch_ready,
	jts_out_if.source           tokens
);

	logic [jts_pkg::SLOTS-1:0]       vld_q;
	jts_pkg::jts_token_t [jts_pkg::SLOTS-1:0] tok_q;
	logic [jts_pkg::SLOTS-1:0]       sel;
	logic [jts_pkg::SLOTS-1:0]       rest;
	jts_pkg::jts_token_t             cur;

	// Lowest pending slot goes out first.
	assign sel  = vld_q & (~vld_q + jts_pkg::SLOTS'(1));
	assign rest = vld_q & ~sel;

	always_comb begin
		cur = '0;
		for (int i = 0; i < jts_pkg::SLOTS; i++) begin
			if (sel[i]) cur = tok_q[i];
		end
	end

	assign tokens.valid        = |vld_q;
	assign tokens.token_kind   = cur.kind;
	assign tokens.token_start  = cur.start;
	assign tokens.token_length = cur.length;
	assign tokens.run_last     = (rest == '0);

	assign batch_ready = (vld_q == '0) || ((rest == '0) && tokens.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (batch_valid && batch_ready) begin
			vld_q <= batch.vld;
		end else if (tokens.valid && tokens.ready) begin
			vld_q <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (batch_valid && batch_ready) begin
			tok_q <= batch.tok;
		end
	end

endmodule

/* rtl/core/json_token_scanner_top.sv */
// Streaming JSON lexer. One document byte enters per transaction on the bytes
// channel (doc_last marks the final byte), and the tokens it completes leave
// on the tokens channel as kind, start offset and length, with run_last set on
// the final token caused by that byte. A byte is registered, scanned in the
// following cycle by short logic against the running lexer state, and its
// zero to three tokens are parked in a result register that drains one token
// per cycle while the receiver is ready. A byte with at most one token is
// taken every cycle on the same condition; one with more holds the result
// register until its last token leaves, so the input rate is set by that
// single output port. Offsets restart from zero after the last byte of each
// document and saturate rather than wrap.

module json_token_scanner_top (
	input  logic      clk,
	input  logic      arst_n,
	jts_in_if.sink    bytes,
	jts_out_if.source tokens
);

	// Tokens of one scanned byte on their way to the result register.
	jts_pkg::jts_batch_t batch;
	logic                batch_valid;
	logic                batch_ready;

	// Input register, scanner state and per-byte token logic.
	jts_lexer u_lexer (
		.clk         (clk),
		.arst_n      (arst_n),
		.bytes       (bytes),
		.batch       (batch),
		.batch_valid (batch_valid),
		.batch_ready (batch_ready)
	);

	// Result register: holds one byte's tokens and presents them in order.
	jts_out u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.batch       (batch),
		.batch_valid (batch_valid),
		.batch_ready (batch_ready),
		.tokens      (tokens)
	);

endmodule

/* tb/tb_json_token_scanner_top.sv */
`timescale 1ns / 1ps

// Byte-stream testbench for the streaming JSON lexer. Documents are built as
// byte queues, fed through the bytes channel by a clocked driver, and every
// token leaving the tokens channel is checked against a lexer model kept
// inside this module.
module tb_json_token_scanner_top;
	import jts_pkg::*;

	// Length of the one long receiver hold that backs the lexer up.
	localparam int HOLD_CYCLES = 80;
	// Cycles allowed after the last token before the verdict.
	localparam int TAIL_CYCLES = 10;

	// Lexer states of the model. Only this file uses them.
	typedef enum logic [3:0] {
		SCAN_IDLE,
		SCAN_STRING,
		SCAN_WORD,
		SCAN_SIGN,
		SCAN_INT,
		SCAN_DOT,
		SCAN_FRAC,
		SCAN_EXP,
		SCAN_EXP_SIGN,
		SCAN_EXP_DIGIT
	} scan_state_t;

	// One transaction on the bytes channel.
	typedef struct packed {
		logic [7:0] value;
		logic       last;
	} doc_byte_t;

	// One transaction on the tokens channel.
	typedef struct packed {
		logic [KIND_BITS-1:0]  kind;
		logic [FIELD_BITS-1:0] start;
		logic [FIELD_BITS-1:0] length;
		logic                  last;
	} token_rec_t;

	logic clk = 1'b0;
	logic arst_n;

	jts_in_if  bytes_ch ();
	jts_out_if tokens_ch ();

	json_token_scanner_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.bytes  (bytes_ch),
		.tokens (tokens_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Bytes waiting for the driver, and the document being assembled.
	doc_byte_t  pending_bytes[$];
	logic [7:0] doc_bytes[$];
	// Tokens the lexer model says must still come out, oldest first.
	token_rec_t expected_tokens[$];

	// Traffic shaping, set by the sequencing block while the lexer is drained.
	int idle_pct = 0;
	int stall_pct = 0;
	int holds_wanted = 0;
	int holds_done;
	int hold_left;

	// Run bookkeeping for the summary and the verdict.
	int mismatches = 0;
	int bytes_accepted = 0;
	int tokens_checked = 0;
	int docs_queued = 0;
	int kinds_seen[16];

	// ------------------------------------------------------------------
	// Lexer model state. It mirrors what the block must remember between
	// bytes: the current scan state, the offset of the next byte, the
	// offset where the pending lexeme began, and the keyword matcher.
	// ------------------------------------------------------------------
	scan_state_t              scan_state = SCAN_IDLE;
	logic [OFFSET_BITS-1:0]   doc_pos = '0;
	logic [OFFSET_BITS-1:0]   tok_begin = '0;
	logic [2:0]               word_len = '0;
	logic [5:0]               word_hits = 6'h3F;

	// Keyword spellings in match order: lower and upper case of each word.
	function automatic int kw_length(input int k);
		return (k == 2 || k == 3) ? 5 : 4;
	endfunction

	function automatic logic [7:0] kw_char(input int k, input int i);
		logic [39:0] text;
		case (k)
			0: text = "true";
			1: text = "TRUE";
			2: text = "false";
			3: text = "FALSE";
			4: text = "null";
			default: text = "NULL";
		endcase
		return text[8 * (kw_length(k) - 1 - i) +: 8];
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return c == " " || (c >= 8'd9 && c <= 8'd13);
	endfunction

	// Narrow the keyword candidates by one more letter. The letter count
	// saturates at seven, which is already longer than any keyword.
	function automatic void word_feed(input logic [7:0] c);
		for (int k = 0; k < 6; k++) begin
			if (word_len >= kw_length(k) || kw_char(k, word_len) != c)
				word_hits[k] = 1'b0;
		end
		if (word_len < 3'd7)
			word_len = word_len + 3'd1;
	endfunction

	function automatic logic [KIND_BITS-1:0] word_kind();
		for (int k = 0; k < 6; k++) begin
			if (word_hits[k] && word_len == kw_length(k))
				return KIND_TRUE + KIND_BITS'(k / 2);
		end
		return KIND_INVALID;
	endfunction

	function automatic void add_token(input logic [KIND_BITS-1:0] kind,
			input logic [63:0] start, input logic [63:0] len);
		token_rec_t t;
		t.kind = kind;
		t.start = start[FIELD_BITS-1:0];
		t.length = (len > 64'hFFFF_FFFF) ? '1 : len[FIELD_BITS-1:0];
		t.last = 1'b0;
		expected_tokens = {expected_tokens, t};
	endfunction

	// Bytes of the pending lexeme up to and including the byte at pos.
	function automatic logic [63:0] span_through(input logic [OFFSET_BITS-1:0] pos);
		logic [63:0] d;
		d = 64'(pos - tok_begin);
		return (d >= 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : d + 64'd1;
	endfunction

	// Run one accepted byte through the model and queue the tokens it causes.
	function automatic void lex_byte(input logic [7:0] c, input logic is_last);
		logic [OFFSET_BITS-1:0] pos;
		logic                   consumed;
		logic                   ends;
		logic [KIND_BITS-1:0]   kind;
		logic [KIND_BITS-1:0]   flush;
		int                     queued;
		pos = doc_pos;
		consumed = 1'b1;
		ends = 1'b0;
		kind = KIND_INVALID;
		queued = expected_tokens.size();

		// First decide what the byte does to a token already in progress.
		case (scan_state)
			SCAN_STRING: begin
				if (c == "\"") begin
					// A string closed by the document's last byte counts as broken.
					add_token(is_last ? KIND_INVALID : KIND_STRING, 64'(tok_begin),
						span_through(pos));
					scan_state = SCAN_IDLE;
				end
			end
			SCAN_WORD: begin
				if (is_alpha(c))
					word_feed(c);
				else begin
					ends = 1'b1;
					kind = word_kind();
				end
			end
			SCAN_SIGN: begin
				if (is_digit(c))
					scan_state = SCAN_INT;
				else
					ends = 1'b1;
			end
			SCAN_INT: begin
				if (c == ".")
					scan_state = SCAN_DOT;
				else if (!is_digit(c)) begin
					ends = 1'b1;
					kind = KIND_INTEGER;
				end
			end
			SCAN_DOT: begin
				if (is_digit(c))
					scan_state = SCAN_FRAC;
				else
					ends = 1'b1;
			end
			SCAN_FRAC: begin
				if (c == "e" || c == "E")
					scan_state = SCAN_EXP;
				else if (!is_digit(c)) begin
					ends = 1'b1;
					kind = KIND_REAL;
				end
			end
			SCAN_EXP: begin
				if (c == "+" || c == "-")
					scan_state = SCAN_EXP_SIGN;
				else if (is_digit(c))
					scan_state = SCAN_EXP_DIGIT;
				else
					ends = 1'b1;
			end
			SCAN_EXP_SIGN: begin
				if (is_digit(c))
					scan_state = SCAN_EXP_DIGIT;
				else
					ends = 1'b1;
			end
			SCAN_EXP_DIGIT: begin
				if (!is_digit(c)) begin
					ends = 1'b1;
					kind = KIND_REAL;
				end
			end
			default: consumed = 1'b0;
		endcase

		// A pending token that this byte does not belong to closes just
		// before it, and the byte is then scanned as the start of a new one.
		if (ends) begin
			add_token(kind, 64'(tok_begin), 64'(pos - tok_begin));
			scan_state = SCAN_IDLE;
			consumed = 1'b0;
		end

		if (!consumed) begin
			case (c)
				"{": add_token(KIND_LBRACE, 64'(pos), 64'd1);
				"}": add_token(KIND_RBRACE, 64'(pos), 64'd1);
				":": add_token(KIND_COLON, 64'(pos), 64'd1);
				",": add_token(KIND_COMMA, 64'(pos), 64'd1);
				"[": add_token(KIND_LBRACKET, 64'(pos), 64'd1);
				"]": add_token(KIND_RBRACKET, 64'(pos), 64'd1);
				"\"": begin
					scan_state = SCAN_STRING;
					tok_begin = pos;
				end
				"+", "-": begin
					scan_state = SCAN_SIGN;
					tok_begin = pos;
				end
				default: begin
					if (is_space(c)) begin
					end else if (is_digit(c)) begin
						scan_state = SCAN_INT;
						tok_begin = pos;
					end else if (is_alpha(c)) begin
						scan_state = SCAN_WORD;
						tok_begin = pos;
						word_len = '0;
						word_hits = 6'h3F;
						word_feed(c);
					end else begin
						// A stray byte is one invalid token of its own.
						add_token(KIND_INVALID, 64'(pos), 64'd1);
					end
				end
			endcase
		end

		if (is_last) begin
			// The last byte flushes whatever is pending and closes the document.
			if (scan_state != SCAN_IDLE) begin
				case (scan_state)
					SCAN_WORD:      flush = word_kind();
					SCAN_INT:       flush = KIND_INTEGER;
					SCAN_FRAC:      flush = KIND_REAL;
					SCAN_EXP_DIGIT: flush = KIND_REAL;
					default:        flush = KIND_INVALID;
				endcase
				add_token(flush, 64'(tok_begin), span_through(pos));
			end
			add_token(KIND_END, (pos == '1) ? 64'(pos) : 64'(pos) + 64'd1, 64'd0);
			scan_state = SCAN_IDLE;
			doc_pos = '0;
			tok_begin = '0;
			word_len = '0;
			word_hits = 6'h3F;
		end else if (doc_pos != '1) begin
			doc_pos = doc_pos + 1'b1;
		end

		if (expected_tokens.size() > queued)
			expected_tokens[expected_tokens.size() - 1].last = 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// Driver. At each edge it first books the transaction that completed
	// (if any) with the model, then either offers the next byte or, with
	// the chance set by idle_pct, leaves the channel idle. A byte once
	// offered stays on the channel until taken.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		doc_byte_t item;
		if (!arst_n) begin
			bytes_ch.valid <= 1'b0;
			bytes_ch.byte_in <= '0;
			bytes_ch.doc_last <= 1'b0;
		end else begin
			if (bytes_ch.valid && bytes_ch.ready) begin
				lex_byte(bytes_ch.byte_in, bytes_ch.doc_last);
				bytes_accepted++;
			end
			if (!bytes_ch.valid || bytes_ch.ready) begin
				if (pending_bytes.size() != 0 && $urandom_range(99) >= idle_pct) begin
					item = pending_bytes.pop_front();
					bytes_ch.valid <= 1'b1;
					bytes_ch.byte_in <= item.value;
					bytes_ch.doc_last <= item.last;
				end else begin
					bytes_ch.valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver ready. Normally it stalls with the chance set by stall_pct.
	// When the sequencing block asks for a hold, ready stays low for the
	// length of a hold counted here, so the lexer's result register fills
	// and it has to push back on the bytes channel.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tokens_ch.ready <= 1'b0;
			hold_left <= 0;
			holds_done <= 0;
		end else if (hold_left != 0) begin
			tokens_ch.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (holds_done < holds_wanted) begin
			tokens_ch.ready <= 1'b0;
			hold_left <= HOLD_CYCLES - 1;
			holds_done <= holds_done + 1;
		end else begin
			tokens_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// ------------------------------------------------------------------
	// Monitor. Every token transaction is matched against the oldest
	// expected token, field by field. A token with nothing expected is a
	// failure of its own.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		token_rec_t want;
		if (arst_n && tokens_ch.valid && tokens_ch.ready) begin
			tokens_checked++;
			kinds_seen[tokens_ch.token_kind]++;
			if (expected_tokens.size() == 0) begin
				mismatches++;
				$display("%0t: token with nothing expected: kind %0d start %0d length %0d",
					$time, tokens_ch.token_kind, tokens_ch.token_start,
					tokens_ch.token_length);
			end else begin
				want = expected_tokens.pop_front();
				if (tokens_ch.token_kind !== want.kind) begin
					mismatches++;
					$display("%0t: token_kind expected %0d actual %0d", $time,
						want.kind, tokens_ch.token_kind);
				end
				if (tokens_ch.token_start !== want.start) begin
					mismatches++;
					$display("%0t: token_start expected %0d actual %0d", $time,
						want.start, tokens_ch.token_start);
				end
				if (tokens_ch.token_length !== want.length) begin
					mismatches++;
					$display("%0t: token_length expected %0d actual %0d", $time,
						want.length, tokens_ch.token_length);
				end
				if (tokens_ch.run_last !== want.last) begin
					mismatches++;
					$display("%0t: run_last expected %0b actual %0b", $time,
						want.last, tokens_ch.run_last);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Document building. Bytes collect in doc_bytes and are moved to the
	// driver's queue as one document, with doc_last on the final byte.
	// ------------------------------------------------------------------
	task automatic add_char(input logic [7:0] c);
		doc_bytes = {doc_bytes, c};
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			add_char(s[i]);
	endtask

	task automatic end_document();
		doc_byte_t item;
		for (int i = 0; i < doc_bytes.size(); i++) begin
			item.value = doc_bytes[i];
			item.last = (i == doc_bytes.size() - 1);
			pending_bytes = {pending_bytes, item};
		end
		if (doc_bytes.size() != 0)
			docs_queued++;
		doc_bytes.delete();
	endtask

	function automatic logic [7:0] random_digit();
		return "0" + 8'($urandom_range(0, 9));
	endfunction

	function automatic logic [7:0] random_space();
		return ($urandom_range(0, 5) == 0) ? " " : 8'($urandom_range(9, 13));
	endfunction

	// Well-formed number: optional sign, digits, and for a real a fraction
	// and sometimes an exponent with an optional sign.
	task automatic add_number(input logic want_real);
		if ($urandom_range(0, 2) == 0)
			add_char($urandom_range(0, 1) ? "-" : "+");
		repeat ($urandom_range(1, 3)) add_char(random_digit());
		if (want_real) begin
			add_char(".");
			repeat ($urandom_range(1, 2)) add_char(random_digit());
			if ($urandom_range(0, 1)) begin
				add_char($urandom_range(0, 1) ? "e" : "E");
				case ($urandom_range(0, 2))
					0: add_char("+");
					1: add_char("-");
					default: ;
				endcase
				repeat ($urandom_range(1, 2)) add_char(random_digit());
			end
		end
	endtask

	// Mostly well-formed tokens with random content, plus some noise: stray
	// bytes of any value, numbers cut off mid-way, and letter runs that are
	// no keyword. Tokens sometimes run together without a separator.
	task automatic random_document();
		int         pick;
		int         k;
		string      word;
		string      punct;
		logic [7:0] c;
		punct = "{}:,[]";
		repeat ($urandom_range(1, 6)) begin
			pick = $urandom_range(0, 19);
			if (pick < 4) begin
				add_char(punct[$urandom_range(0, 5)]);
			end else if (pick < 7) begin
				add_char("\"");
				repeat ($urandom_range(0, 4)) begin
					do c = 8'($urandom_range(32, 126)); while (c == "\"");
					add_char(c);
				end
				add_char("\"");
			end else if (pick < 10) begin
				add_number(1'b0);
			end else if (pick < 13) begin
				add_number(1'b1);
			end else if (pick < 16) begin
				k = $urandom_range(0, 5);
				word = "";
				for (int i = 0; i < kw_length(k); i++)
					word = {word, string'(kw_char(k, i))};
				// Now and then the word is cut short by one letter.
				if ($urandom_range(0, 3) == 0)
					word = word.substr(0, word.len() - 2);
				add_text(word);
			end else if (pick == 16) begin
				add_char(random_space());
			end else if (pick == 17) begin
				add_char(8'($urandom_range(0, 255)));
			end else if (pick == 18) begin
				case ($urandom_range(0, 4))
					0: add_text("-");
					1: add_text("7.");
					2: add_text("3e");
					3: add_text("4E-");
					default: add_text("+x");
				endcase
			end else begin
				repeat ($urandom_range(1, 6)) begin
					c = 8'($urandom_range(0, 25));
					add_char(($urandom_range(0, 1) ? "a" : "A") + c);
				end
			end
			if ($urandom_range(0, 2) != 0)
				add_char(random_space());
		end
		end_document();
	endtask

	// Returns once every byte has been taken and every token has come out.
	task automatic wait_drained();
		do @(negedge clk);
		while (pending_bytes.size() != 0 || bytes_ch.valid || expected_tokens.size() != 0);
	endtask

	task automatic run_phase(input int idle, input int stall, input int byte_count);
		idle_pct = idle;
		stall_pct = stall;
		while (pending_bytes.size() < byte_count)
			random_document();
		wait_drained();
	endtask

	// ------------------------------------------------------------------
	// Sequencing: reset, a directed set of documents, random documents
	// under four idle and stall mixes, then a burst against a long receiver hold.
	// ------------------------------------------------------------------
	initial begin
		int kinds_hit;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Object with a string key and a real that the closing brace ends.
		add_text("{\"k\":1.5}");
		end_document();
		// Keyword inside brackets.
		add_text("[true]");
		end_document();
		// Two stray bytes at the extremes of the byte range, a sign broken
		// by a dot, the dot itself as a stray, and an integer flushed by the
		// last byte.
		add_char(8'hFF);
		add_char(8'h00);
		add_text("-.7");
		end_document();
		// A string closed by the last byte of the document is invalid.
		add_text("\"a\"");
		end_document();
		// So is a string still open at the last byte.
		add_text("\"a");
		end_document();
		wait_drained();

		run_phase(0, 0, 10);
		run_phase(73, 0, 10);
		run_phase(0, 73, 10);
		run_phase(34, 34, 10);

		// Sender keeps offering while the receiver holds off for a long while.
		idle_pct = 0;
		stall_pct = 0;
		while (pending_bytes.size() < 16)
			random_document();
		holds_wanted = 1;
		wait_drained();

		repeat (TAIL_CYCLES) @(negedge clk);
		if (expected_tokens.size() != 0) begin
			mismatches += expected_tokens.size();
			$display("%0t: %0d expected tokens never arrived", $time,
				expected_tokens.size());
		end

		kinds_hit = 0;
		for (int i = 0; i < 14; i++)
			if (kinds_seen[i] != 0)
				kinds_hit++;
		$display("Lexed %0d bytes in %0d documents into %0d tokens, %0d of 14 kinds seen,",
			bytes_accepted, docs_queued, tokens_checked, kinds_hit);
		$display("across idle and stall mixes and one %0d-cycle receiver hold.",
			HOLD_CYCLES);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run of about a hundred bytes.
	initial begin
		#2_000_000;
		$display("Timed out with %0d tokens still expected", expected_tokens.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

/* files.f */
rtl/core/jts_pkg.sv
rtl/core/jts_in_if.sv
rtl/core/jts_out_if.sv
rtl/core/jts_lexer.sv
rtl/core/jts_out.sv
rtl/core/json_token_scanner_top.sv
tb/tb_json_token_scanner_top.sv
